FILE: design/mstp_pkg.sv
// Shared constants, request and register codes, and memory control type
// for the Prim spanning-tree block. No dependencies.

package mstp_pkg;

  // Default sizes handed to the top level's parameters.
  localparam int DEF_MAX_VERTICES = 32;
  localparam int DEF_WEIGHT_BITS  = 16;

  // Fixed field widths of the channels and configuration port.
  localparam int TYPE_W     = 2;
  localparam int IDX_W      = 5;
  localparam int WT_W       = 16;
  localparam int CNT_W      = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;
  // Width used for vertex counts and index compares (holds up to 64 and more).
  localparam int SCAN_W     = 8;

  // Request types.
  localparam logic [TYPE_W-1:0] REQ_CLEAR = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_ADD   = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_RUN   = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_VERTEX = 1'd1;

  // Configuration reset values.
  localparam logic [CNT_W-1:0] VERTEX_COUNT_RST = 6'd32;
  localparam logic [IDX_W-1:0] START_VERTEX_RST = 5'd0;

  // Control strobes from the sequencer to the adjacency store.
  typedef struct packed {
    logic clr;
    logic wt_we;
    logic row_we;
  } adj_ctl_t;

endpackage

FILE: design/mstp_if.sv
// Valid/ready channel interfaces for request beats and result beats.
// Depends on mstp_pkg for field widths.

interface mstp_req_if;
  logic                               valid;
  logic                               ready;
  logic [mstp_pkg::TYPE_W-1:0]        req_type;
  logic [mstp_pkg::IDX_W-1:0]         edge_from;
  logic [mstp_pkg::IDX_W-1:0]         edge_to;
  logic signed [mstp_pkg::WT_W-1:0]   edge_weight;

  modport source (output valid, req_type, edge_from, edge_to, edge_weight, input ready);
  modport sink   (input valid, req_type, edge_from, edge_to, edge_weight, output ready);
endinterface

interface mstp_res_if;
  logic                               valid;
  logic                               ready;
  logic [mstp_pkg::IDX_W-1:0]         vertex_index;
  logic                               has_parent;
  logic [mstp_pkg::IDX_W-1:0]         parent_index;
  logic signed [mstp_pkg::WT_W-1:0]   tree_weight;
  logic                               last_result;

  modport source (output valid, vertex_index, has_parent, parent_index, tree_weight,
                  last_result, input ready);
  modport sink   (input valid, vertex_index, has_parent, parent_index, tree_weight,
                  last_result, output ready);
endinterface

FILE: design/mstp_cmp.sv
// Shared key compare unit: signed less-than with an infinity flag on each side.
// Depends on mstp_pkg for the default weight width.

module mstp_cmp #(
  parameter int WEIGHT_BITS = mstp_pkg::DEF_WEIGHT_BITS
) (
  input  logic                          a_inf,
  input  logic signed [WEIGHT_BITS-1:0] a_val,
  input  logic                          b_inf,
  input  logic signed [WEIGHT_BITS-1:0] b_val,
  output logic                          lt
);

  // A finite value is below infinity; infinity is never below anything.
  assign lt = !a_inf && (b_inf || (a_val < b_val));

endmodule

FILE: design/mstp_adj_mem.sv
// Adjacency store: edge weight memory plus present-bit rows with row valid bits.
// Depends on mstp_pkg for the control strobe type.

module mstp_adj_mem #(
  parameter int MAX_VERTICES = mstp_pkg::DEF_MAX_VERTICES,
  parameter int WEIGHT_BITS  = mstp_pkg::DEF_WEIGHT_BITS,
  localparam int VW          = $clog2(MAX_VERTICES)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mstp_pkg::adj_ctl_t            ctl,
  input  logic [2*VW-1:0]               wt_waddr,
  input  logic signed [WEIGHT_BITS-1:0] wt_wdata,
  input  logic [2*VW-1:0]               wt_raddr,
  output logic signed [WEIGHT_BITS-1:0] wt_rdata,
  input  logic [VW-1:0]                 row_waddr,
  input  logic [MAX_VERTICES-1:0]       row_wdata,
  input  logic [VW-1:0]                 row_raddr,
  output logic [MAX_VERTICES-1:0]       row_rdata
);

  localparam int DEPTH = 1 << (2 * VW);

  logic signed [WEIGHT_BITS-1:0] wt_mem [DEPTH];
  logic [MAX_VERTICES-1:0]       row_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0]       row_valid;
  logic [MAX_VERTICES-1:0]       row_q;
  logic                          row_vq;

  // Memory arrays: one write and one registered read per cycle each.
  always_ff @(posedge clk) begin
    if (ctl.wt_we) begin
      wt_mem[wt_waddr] <= wt_wdata;
    end
    wt_rdata <= wt_mem[wt_raddr];
    if (ctl.row_we) begin
      row_mem[row_waddr] <= row_wdata;
    end
    row_q <= row_mem[row_raddr];
  end

  // Row valid bits; a clear drops every row at once.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      row_vq    <= 1'b0;
    end else begin
      if (ctl.clr) begin
        row_valid <= '0;
      end else if (ctl.row_we) begin
        row_valid[row_waddr] <= 1'b1;
      end
      row_vq <= row_valid[row_raddr];
    end
  end

  // A row never written since the last clear reads as no edges.
  assign row_rdata = row_vq ? row_q : '0;

endmodule

FILE: design/mstp_ctrl.sv
// Sequencer for edge loading, Prim rounds and result emission, with vertex state.
// Depends on mstp_pkg and the channel interfaces in mstp_if.

module mstp_ctrl #(
  parameter int MAX_VERTICES = mstp_pkg::DEF_MAX_VERTICES,
  parameter int WEIGHT_BITS  = mstp_pkg::DEF_WEIGHT_BITS,
  localparam int VW          = $clog2(MAX_VERTICES)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [mstp_pkg::SCAN_W-1:0]     n_eff,
  input  logic [mstp_pkg::IDX_W-1:0]      start_vertex,
  mstp_req_if.sink                        req,
  mstp_res_if.source                      res,
  output mstp_pkg::adj_ctl_t              ctl,
  output logic [2*VW-1:0]                 wt_waddr,
  output logic signed [WEIGHT_BITS-1:0]   wt_wdata,
  output logic [2*VW-1:0]                 wt_raddr,
  input  logic signed [WEIGHT_BITS-1:0]   wt_rdata,
  output logic [VW-1:0]                   row_waddr,
  output logic [MAX_VERTICES-1:0]         row_wdata,
  output logic [VW-1:0]                   row_raddr,
  input  logic [MAX_VERTICES-1:0]         row_rdata,
  output logic                            cmp_a_inf,
  output logic signed [WEIGHT_BITS-1:0]   cmp_a,
  output logic                            cmp_b_inf,
  output logic signed [WEIGHT_BITS-1:0]   cmp_b,
  input  logic                            cmp_lt
);

  localparam int SW = mstp_pkg::SCAN_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_CMP,
    ST_ADD_WR2,
    ST_SEL,
    ST_SEL_END,
    ST_RELAX_RD,
    ST_RELAX_UPD,
    ST_EMIT,
    ST_DRAIN
  } state_t;

  state_t state;

  // Latched edge of the request being loaded.
  logic [VW-1:0]                 ea;
  logic [VW-1:0]                 eb;
  logic signed [WEIGHT_BITS-1:0] ew;

  // Scan index and the running minimum of the selection pass.
  logic [VW-1:0]                 idx;
  logic [VW-1:0]                 best;
  logic                          found;
  logic                          best_inf;
  logic signed [WEIGHT_BITS-1:0] best_key;

  // Per-vertex state.
  logic signed [WEIGHT_BITS-1:0] key [MAX_VERTICES];
  logic [VW-1:0]                 par [MAX_VERTICES];
  logic [MAX_VERTICES-1:0]       key_inf;
  logic [MAX_VERTICES-1:0]       has_par;
  logic [MAX_VERTICES-1:0]       in_tree;

  // Result register.
  logic                          res_valid;
  logic [mstp_pkg::IDX_W-1:0]    r_index;
  logic                          r_hp;
  logic [mstp_pkg::IDX_W-1:0]    r_par;
  logic signed [mstp_pkg::WT_W-1:0] r_wt;
  logic                          r_last;

  // Decoded request fields and scan helpers.
  logic [SW-1:0]                 a8;
  logic [SW-1:0]                 b8;
  logic [SW-1:0]                 s8;
  logic [SW-1:0]                 idx8;
  logic [SW-1:0]                 par8;
  logic signed [31:0]            w32;
  logic [31:0]                   kz;
  logic                          edge_ok;
  logic                          start_ok;
  logic                          idx_last;
  logic [MAX_VERTICES-1:0]       bit_a;
  logic [MAX_VERTICES-1:0]       bit_b;
  logic [MAX_VERTICES-1:0]       bit_s;

  always_comb begin
    a8       = SW'(req.edge_from);
    b8       = SW'(req.edge_to);
    s8       = SW'(start_vertex);
    w32      = 32'(req.edge_weight);
    edge_ok  = (a8 < SW'(MAX_VERTICES)) && (b8 < SW'(MAX_VERTICES));
    start_ok = s8 < n_eff;
    idx8     = SW'(idx);
    idx_last = idx8 == (n_eff - SW'(1));
    par8     = SW'(par[idx]);
    kz       = 32'($unsigned(key[idx]));
    bit_a    = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << ea;
    bit_b    = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << eb;
    bit_s    = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << s8[VW-1:0];
  end

  // Memory addressing and compare operands, chosen by state.
  always_comb begin
    ctl       = '0;
    wt_waddr  = {ea, eb};
    wt_raddr  = {ea, eb};
    wt_wdata  = ew;
    row_waddr = ea;
    row_raddr = ea;
    row_wdata = row_rdata | bit_b;
    cmp_a_inf = 1'b0;
    cmp_a     = ew;
    cmp_b_inf = 1'b1;
    cmp_b     = wt_rdata;
    case (state)
      ST_IDLE: begin
        ctl.clr = req.valid && (req.req_type == mstp_pkg::REQ_CLEAR);
      end
      ST_ADD_CMP: begin
        // New weight wins when no edge is stored or it is strictly smaller.
        cmp_b_inf  = !row_rdata[eb];
        ctl.wt_we  = cmp_lt;
        ctl.row_we = cmp_lt;
        row_raddr  = eb;
      end
      ST_ADD_WR2: begin
        wt_waddr   = {eb, ea};
        row_waddr  = eb;
        row_wdata  = row_rdata | bit_a;
        ctl.wt_we  = 1'b1;
        ctl.row_we = 1'b1;
      end
      ST_SEL: begin
        cmp_a_inf = key_inf[idx];
        cmp_a     = key[idx];
        cmp_b_inf = best_inf;
        cmp_b     = best_key;
      end
      ST_RELAX_RD: begin
        wt_raddr  = {best, idx};
        row_raddr = best;
      end
      ST_RELAX_UPD: begin
        cmp_a     = wt_rdata;
        cmp_b_inf = key_inf[idx];
        cmp_b     = key[idx];
      end
      default: begin
      end
    endcase
  end

  // Sequencer, vertex state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx       <= '0;
      found     <= 1'b0;
      key_inf   <= '1;
      has_par   <= '0;
      in_tree   <= '0;
      res_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            ea <= a8[VW-1:0];
            eb <= b8[VW-1:0];
            ew <= w32[WEIGHT_BITS-1:0];
            case (req.req_type)
              mstp_pkg::REQ_ADD: begin
                if (edge_ok) begin
                  state <= ST_ADD_RD;
                end
              end
              mstp_pkg::REQ_RUN: begin
                // Fresh keys; only an in-range start vertex gets key zero.
                in_tree <= '0;
                has_par <= '0;
                key_inf <= start_ok ? ~bit_s : '1;
                if (start_ok) begin
                  key[s8[VW-1:0]] <= '0;
                end
                idx   <= '0;
                found <= 1'b0;
                state <= ST_SEL;
              end
              default: begin
              end
            endcase
          end
        end
        ST_ADD_RD: begin
          state <= ST_ADD_CMP;
        end
        ST_ADD_CMP: begin
          state <= cmp_lt ? ST_ADD_WR2 : ST_IDLE;
        end
        ST_ADD_WR2: begin
          state <= ST_IDLE;
        end
        ST_SEL: begin
          // Lowest index wins ties since only a strictly smaller key replaces.
          if (!in_tree[idx] && (!found || cmp_lt)) begin
            best     <= idx;
            best_inf <= key_inf[idx];
            best_key <= key[idx];
            found    <= 1'b1;
          end
          if (idx_last) begin
            state <= ST_SEL_END;
          end else begin
            idx <= idx + VW'(1);
          end
        end
        ST_SEL_END: begin
          idx <= '0;
          if (!found) begin
            state <= ST_EMIT;
          end else begin
            in_tree[best] <= 1'b1;
            state         <= ST_RELAX_RD;
          end
        end
        ST_RELAX_RD: begin
          state <= ST_RELAX_UPD;
        end
        ST_RELAX_UPD: begin
          if (!in_tree[idx] && row_rdata[idx] && cmp_lt) begin
            key[idx]     <= wt_rdata;
            key_inf[idx] <= 1'b0;
            has_par[idx] <= 1'b1;
            par[idx]     <= best;
          end
          if (idx_last) begin
            idx   <= '0;
            found <= 1'b0;
            state <= ST_SEL;
          end else begin
            idx   <= idx + VW'(1);
            state <= ST_RELAX_RD;
          end
        end
        ST_EMIT: begin
          // Load the next result whenever the register is empty or being taken.
          if (!res_valid || res.ready) begin
            res_valid <= 1'b1;
            r_index   <= idx8[mstp_pkg::IDX_W-1:0];
            r_hp      <= has_par[idx];
            r_par     <= has_par[idx] ? par8[mstp_pkg::IDX_W-1:0] : '0;
            r_wt      <= has_par[idx] ? kz[mstp_pkg::WT_W-1:0] : '0;
            r_last    <= idx_last;
            if (idx_last) begin
              state <= ST_DRAIN;
            end else begin
              idx <= idx + VW'(1);
            end
          end
        end
        ST_DRAIN: begin
          if (res.ready) begin
            res_valid <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign req.ready        = (state == ST_IDLE);
  assign res.valid        = res_valid;
  assign res.vertex_index = r_index;
  assign res.has_parent   = r_hp;
  assign res.parent_index = r_par;
  assign res.tree_weight  = r_wt;
  assign res.last_result  = r_last;

endmodule

FILE: design/minimum_spanning_tree_prim_top.sv
// Top level of the Prim spanning-forest block: configuration registers and wiring
// of sequencer, adjacency store and compare unit. Depends on mstp_pkg and mstp_if.
//
// Usage: request beats arrive on req (valid/ready). A clear beat drops all edges at
// once. An add-edge beat stores the edge both ways, keeping the smaller weight, after
// reading the stored one; edges with an endpoint beyond the store are dropped.
// A run beat grows a forest from start_vertex over n = clamped vertex_count vertices
// and then sends n result beats on res, vertex 0 first, last_result on vertex n-1.
// In a run, each round scans n keys through the one compare unit, then reads one
// weight per vertex from the registered-read weight memory and relaxes its key.
// After the last round, results leave one per cycle while the receiver is ready; a
// stall holds the result register and the sequencer.
// req.ready is high only while idle, so one beat is worked on at a time.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// Reset (synchronous, rst high) empties the graph, sets vertex_count to 32 and
// start_vertex to 0, and drops any result in flight.

module minimum_spanning_tree_prim_top #(
  parameter int MAX_VERTICES = mstp_pkg::DEF_MAX_VERTICES,
  parameter int WEIGHT_BITS  = mstp_pkg::DEF_WEIGHT_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [mstp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mstp_pkg::CFG_DATA_W-1:0]    cfg_data,
  mstp_req_if.sink                           req,
  mstp_res_if.source                         res
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int SW = mstp_pkg::SCAN_W;

  logic [mstp_pkg::CNT_W-1:0]    vertex_count;
  logic [mstp_pkg::IDX_W-1:0]    start_vertex;
  logic [SW-1:0]                 cnt8;
  logic [SW-1:0]                 n_eff;

  mstp_pkg::adj_ctl_t            ctl;
  logic [2*VW-1:0]               wt_waddr;
  logic signed [WEIGHT_BITS-1:0] wt_wdata;
  logic [2*VW-1:0]               wt_raddr;
  logic signed [WEIGHT_BITS-1:0] wt_rdata;
  logic [VW-1:0]                 row_waddr;
  logic [MAX_VERTICES-1:0]       row_wdata;
  logic [VW-1:0]                 row_raddr;
  logic [MAX_VERTICES-1:0]       row_rdata;
  logic                          cmp_a_inf;
  logic signed [WEIGHT_BITS-1:0] cmp_a;
  logic                          cmp_b_inf;
  logic signed [WEIGHT_BITS-1:0] cmp_b;
  logic                          cmp_lt;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= mstp_pkg::VERTEX_COUNT_RST;
      start_vertex <= mstp_pkg::START_VERTEX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mstp_pkg::REG_VERTEX_COUNT: vertex_count <= cfg_data[mstp_pkg::CNT_W-1:0];
        mstp_pkg::REG_START_VERTEX: start_vertex <= cfg_data[mstp_pkg::IDX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Vertex count in use: zero acts as one, anything above the store is capped.
  always_comb begin
    cnt8 = SW'(vertex_count);
    if (cnt8 == '0) begin
      n_eff = SW'(1);
    end else if (cnt8 > SW'(MAX_VERTICES)) begin
      n_eff = SW'(MAX_VERTICES);
    end else begin
      n_eff = cnt8;
    end
  end

  mstp_ctrl #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .n_eff        (n_eff),
    .start_vertex (start_vertex),
    .req          (req),
    .res          (res),
    .ctl          (ctl),
    .wt_waddr     (wt_waddr),
    .wt_wdata     (wt_wdata),
    .wt_raddr     (wt_raddr),
    .wt_rdata     (wt_rdata),
    .row_waddr    (row_waddr),
    .row_wdata    (row_wdata),
    .row_raddr    (row_raddr),
    .row_rdata    (row_rdata),
    .cmp_a_inf    (cmp_a_inf),
    .cmp_a        (cmp_a),
    .cmp_b_inf    (cmp_b_inf),
    .cmp_b        (cmp_b),
    .cmp_lt       (cmp_lt)
  );

  mstp_adj_mem #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_adj_mem (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .wt_waddr  (wt_waddr),
    .wt_wdata  (wt_wdata),
    .wt_raddr  (wt_raddr),
    .wt_rdata  (wt_rdata),
    .row_waddr (row_waddr),
    .row_wdata (row_wdata),
    .row_raddr (row_raddr),
    .row_rdata (row_rdata)
  );

  mstp_cmp #(
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_cmp (
    .a_inf (cmp_a_inf),
    .a_val (cmp_a),
    .b_inf (cmp_b_inf),
    .b_val (cmp_b),
    .lt    (cmp_lt)
  );

endmodule

FILE: design/mstp_chk.sv
// Port-level checker for the Prim spanning-forest top level, and its bind.
// Depends on mstp_pkg for field widths.

module mstp_chk (
  input logic                             clk,
  input logic                             rst,
  input logic                             req_valid,
  input logic                             req_ready,
  input logic                             res_valid,
  input logic                             res_ready,
  input logic [mstp_pkg::IDX_W-1:0]       vertex_index,
  input logic                             has_parent,
  input logic [mstp_pkg::IDX_W-1:0]       parent_index,
  input logic [mstp_pkg::WT_W-1:0]        tree_weight,
  input logic                             last_result
);

  // A stalled result beat stays put.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(vertex_index) && $stable(last_result))
    else $error("result beat changed while stalled");

  // No request is taken while results are still going out.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !req_ready)
    else $error("request ready while results pending");

  // Results of one run follow each other in vertex order without a gap.
  a_next: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && !last_result |=>
      res_valid && (vertex_index == $past(vertex_index) + mstp_pkg::IDX_W'(1)))
    else $error("result sequence broken");

  // A root carries no parent and no weight.
  a_root: assert property (@(posedge clk) disable iff (rst)
    res_valid && !has_parent |-> (parent_index == '0) && (tree_weight == '0))
    else $error("root result with parent fields set");

endmodule

bind minimum_spanning_tree_prim_top mstp_chk u_mstp_chk (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .vertex_index (res.vertex_index),
  .has_parent   (res.has_parent),
  .parent_index (res.parent_index),
  .tree_weight  (res.tree_weight),
  .last_result  (res.last_result)
);

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the Prim spanning-forest block: a directed table of
// request beats, then random graph phases, all checked against an in-bench predictor.
// Depends on mstp_pkg, mstp_req_if/mstp_res_if and minimum_spanning_tree_prim_top.

module tb_top;

  localparam int VMAX = mstp_pkg::DEF_MAX_VERTICES;
  localparam int NO_PARENT = -1;
  // Request code that the block has to ignore.
  localparam logic [mstp_pkg::TYPE_W-1:0] REQ_UNUSED = 2'd3;
  // An add-edge beat may still be at work when the last tree beat arrives.
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD = 600;
  localparam int PHASE_ITEMS = 57;
  localparam int NUM_PHASES = 6;

  typedef struct packed {
    logic [mstp_pkg::TYPE_W-1:0]      rtype;
    logic [mstp_pkg::IDX_W-1:0]       a;
    logic [mstp_pkg::IDX_W-1:0]       b;
    logic signed [mstp_pkg::WT_W-1:0] w;
  } graph_req_t;

  typedef struct packed {
    logic [mstp_pkg::IDX_W-1:0]       vertex;
    logic                             has_parent;
    logic [mstp_pkg::IDX_W-1:0]       parent;
    logic signed [mstp_pkg::WT_W-1:0] weight;
    logic                             last;
  } tree_beat_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  // One line of the directed table: a request beat or a register write, with up
  // to two tree beats typed in where they are obvious.
  typedef struct packed {
    row_kind_t                       kind;
    graph_req_t                      rq;
    logic [mstp_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [mstp_pkg::CFG_DATA_W-1:0] cfg_val;
    logic [1:0]                      n_typed;
    tree_beat_t                      first;
    tree_beat_t                      second;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [mstp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [mstp_pkg::CFG_DATA_W-1:0] cfg_data;

  mstp_req_if req_ch ();
  mstp_res_if res_ch ();

  minimum_spanning_tree_prim_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .res       (res_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state: the graph, the registers and the tree beats still due.
  bit adj_on [VMAX][VMAX];
  logic signed [mstp_pkg::WT_W-1:0] adj_wt [VMAX][VMAX];
  logic [mstp_pkg::CNT_W-1:0] model_count = mstp_pkg::VERTEX_COUNT_RST;
  logic [mstp_pkg::IDX_W-1:0] model_start = mstp_pkg::START_VERTEX_RST;
  tree_beat_t forest_out[$];
  tree_beat_t tree_due[$];

  int req_idle_pct = 9;
  int res_idle_pct = 48;
  int stall_asked = 0;
  int stall_seen = 0;
  int n_errors = 0;
  int n_checked = 0;
  int n_beats = 0;
  int n_runs = 0;
  int n_settings = 0;

  function automatic int clamped_count();
    int n;
    n = model_count;
    if (n < 1) n = 1;
    if (n > VMAX) n = VMAX;
    return n;
  endfunction

  // Parallel edges keep the smaller weight; the store is symmetric.
  function automatic void store_edge(int a, int b, logic signed [mstp_pkg::WT_W-1:0] w);
    if (!adj_on[a][b] || w < adj_wt[a][b]) begin
      adj_wt[a][b] = w;
      adj_wt[b][a] = w;
      adj_on[a][b] = 1'b1;
      adj_on[b][a] = 1'b1;
    end
  endfunction

  // Prim's rule over the first n vertices; fills forest_out with one beat per vertex.
  function automatic void grow_forest();
    int n, u, i, rnd;
    int key [VMAX];
    bit kinf [VMAX];
    int par [VMAX];
    bit done [VMAX];
    tree_beat_t bt;
    n = clamped_count();
    for (i = 0; i < VMAX; i++) begin
      key[i] = 0;
      kinf[i] = 1'b1;
      par[i] = NO_PARENT;
      done[i] = 1'b0;
    end
    if (int'(model_start) < n) kinf[model_start] = 1'b0;
    for (rnd = 0; rnd < n; rnd++) begin
      // Least finite key wins; ties and all-infinite keys go to the lowest index.
      u = -1;
      for (i = 0; i < n; i++) begin
        if (done[i]) continue;
        if (u < 0) u = i;
        else if (!kinf[i] && (kinf[u] || key[i] < key[u])) u = i;
      end
      if (u < 0) break;
      done[u] = 1'b1;
      for (i = 0; i < n; i++) begin
        if (done[i] || !adj_on[u][i]) continue;
        if (kinf[i] || int'(adj_wt[u][i]) < key[i]) begin
          kinf[i] = 1'b0;
          key[i] = adj_wt[u][i];
          par[i] = u;
        end
      end
    end
    forest_out.delete();
    for (i = 0; i < n; i++) begin
      bt = '0;
      bt.vertex = mstp_pkg::IDX_W'(i);
      bt.has_parent = (par[i] != NO_PARENT);
      if (bt.has_parent) begin
        bt.parent = mstp_pkg::IDX_W'(par[i]);
        bt.weight = key[i][mstp_pkg::WT_W-1:0];
      end
      bt.last = (i == n - 1);
      forest_out.push_back(bt);
    end
  endfunction

  function automatic void book_request(graph_req_t r);
    case (r.rtype)
      mstp_pkg::REQ_CLEAR: begin
        foreach (adj_on[i, j]) adj_on[i][j] = 1'b0;
      end
      mstp_pkg::REQ_ADD: store_edge(r.a, r.b, r.w);
      mstp_pkg::REQ_RUN: begin
        grow_forest();
        n_runs++;
      end
      default: ;
    endcase
  endfunction

  function automatic tree_beat_t beat_of(int v, bit hp, int p, int w, bit last);
    tree_beat_t bt;
    bt.vertex = mstp_pkg::IDX_W'(v);
    bt.has_parent = hp;
    bt.parent = mstp_pkg::IDX_W'(p);
    bt.weight = mstp_pkg::WT_W'(w);
    bt.last = last;
    return bt;
  endfunction

  function automatic dir_row_t req_row(logic [mstp_pkg::TYPE_W-1:0] t, int a, int b, int w);
    dir_row_t row;
    row = '0;
    row.kind = ROW_REQ;
    row.rq.rtype = t;
    row.rq.a = mstp_pkg::IDX_W'(a);
    row.rq.b = mstp_pkg::IDX_W'(b);
    row.rq.w = mstp_pkg::WT_W'(w);
    return row;
  endfunction

  function automatic dir_row_t cfg_row(logic [mstp_pkg::CFG_IDX_W-1:0] idx, int val);
    dir_row_t row;
    row = '0;
    row.kind = ROW_CFG;
    row.cfg_idx = idx;
    row.cfg_val = mstp_pkg::CFG_DATA_W'(val);
    return row;
  endfunction

  function automatic dir_row_t run_row(int n_typed, tree_beat_t first, tree_beat_t second);
    dir_row_t row;
    row = req_row(mstp_pkg::REQ_RUN, 0, 0, 0);
    row.n_typed = 2'(n_typed);
    row.first = first;
    row.second = second;
    return row;
  endfunction

  function automatic logic signed [mstp_pkg::WT_W-1:0] pick_weight();
    case ($urandom_range(3))
      0: return mstp_pkg::WT_W'($urandom_range(8) - 4);  // narrow range makes key ties likely
      1: begin
        case ($urandom_range(3))
          0: return 16'sh8000;
          1: return 16'sh7FFF;
          2: return -16'sd1;
          default: return 16'sd0;
        endcase
      end
      default: return mstp_pkg::WT_W'($urandom);
    endcase
  endfunction

  // Mostly edges inside the vertex range, with runs, clears and some noise.
  function automatic graph_req_t pick_request(int n);
    graph_req_t r;
    int roll;
    roll = $urandom_range(99);
    r.rtype = mstp_pkg::REQ_ADD;
    r.a = mstp_pkg::IDX_W'($urandom_range(n - 1));
    r.b = mstp_pkg::IDX_W'($urandom_range(n - 1));
    r.w = pick_weight();
    if (roll >= 70 && roll < 80) begin
      r.a = mstp_pkg::IDX_W'($urandom_range(VMAX - 1));
      r.b = mstp_pkg::IDX_W'($urandom_range(VMAX - 1));
    end else if (roll >= 80 && roll < 90) begin
      r.rtype = mstp_pkg::REQ_RUN;
    end else if (roll >= 90 && roll < 95) begin
      r.rtype = mstp_pkg::REQ_CLEAR;
    end else if (roll >= 95) begin
      r.rtype = REQ_UNUSED;
    end
    return r;
  endfunction

  // Offer one request beat and book it at the edge where it is taken.
  task automatic send_beat(graph_req_t r, int n_typed, tree_beat_t first, tree_beat_t second);
    req_ch.valid <= 1'b1;
    req_ch.req_type <= r.rtype;
    req_ch.edge_from <= r.a;
    req_ch.edge_to <= r.b;
    req_ch.edge_weight <= r.w;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    book_request(r);
    n_beats++;
    if (r.rtype == mstp_pkg::REQ_RUN) begin
      if (n_typed == 0) begin
        foreach (forest_out[i]) tree_due.push_back(forest_out[i]);
      end else begin
        tree_due.push_back(first);
        if (n_typed > 1) tree_due.push_back(second);
      end
    end
  endtask

  task automatic sender_gap();
    if ($urandom_range(99) < req_idle_pct) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < req_idle_pct);
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (tree_due.size() != 0);
  endtask

  // Bring the block to idle before a register write.
  task automatic settle();
    req_ch.valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [mstp_pkg::CFG_IDX_W-1:0] idx,
                           logic [mstp_pkg::CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == mstp_pkg::REG_VERTEX_COUNT) model_count = val;
    else model_start = val[mstp_pkg::IDX_W-1:0];
    n_settings++;
  endtask

  task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
    if (got !== want) begin
      $error("%s expected %0d actual %0d", name, want, got);
      n_errors++;
    end
  endtask

  task automatic check_beat();
    tree_beat_t want;
    if (tree_due.size() == 0) begin
      $error("tree beat for vertex %0d arrived with nothing due", res_ch.vertex_index);
      n_errors++;
      return;
    end
    want = tree_due.pop_front();
    n_checked++;
    check_field("vertex_index", want.vertex, res_ch.vertex_index);
    check_field("has_parent", want.has_parent, res_ch.has_parent);
    check_field("parent_index", want.parent, res_ch.parent_index);
    check_field("tree_weight", want.weight, res_ch.tree_weight);
    check_field("last_result", want.last, res_ch.last_result);
  endtask

  // Result side: check each beat, stall at random, and honor one long hold-off.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) check_beat();
      if (stall_seen != stall_asked) begin
        stall_seen = stall_asked;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= !rst && ($urandom_range(99) >= res_idle_pct);
      end
    end
  end

  initial begin : stimulus
    dir_row_t tab[$];
    graph_req_t r;
    int phase, made, cnt, st;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.req_type = mstp_pkg::REQ_CLEAR;
    req_ch.edge_from = '0;
    req_ch.edge_to = '0;
    req_ch.edge_weight = '0;

    // Empty graph at reset defaults: every vertex is its own root.
    tab.push_back(run_row(0, '0, '0));
    // A single vertex.
    tab.push_back(cfg_row(mstp_pkg::REG_VERTEX_COUNT, 1));
    tab.push_back(run_row(1, beat_of(0, 0, 0, 0, 1), '0));
    // Weight extremes and a larger parallel edge that must not replace the first.
    tab.push_back(cfg_row(mstp_pkg::REG_VERTEX_COUNT, 2));
    tab.push_back(req_row(mstp_pkg::REQ_ADD, 0, 1, -32768));
    tab.push_back(req_row(mstp_pkg::REQ_ADD, 1, 0, 32767));
    tab.push_back(run_row(2, beat_of(0, 0, 0, 0, 0), beat_of(1, 1, 0, -32768, 1)));
    // After a clear, a self loop and an edge beyond the count leave vertex 1 unreached.
    tab.push_back(req_row(mstp_pkg::REQ_CLEAR, 31, 31, -1));
    tab.push_back(req_row(mstp_pkg::REQ_ADD, 1, 1, 5));
    tab.push_back(req_row(mstp_pkg::REQ_ADD, 0, 31, 100));
    tab.push_back(req_row(REQ_UNUSED, 31, 31, -1));
    tab.push_back(run_row(2, beat_of(0, 0, 0, 0, 0), beat_of(1, 0, 0, 0, 1)));
    // A count of zero acts as one; start beyond the count presets no key.
    tab.push_back(cfg_row(mstp_pkg::REG_VERTEX_COUNT, 0));
    tab.push_back(cfg_row(mstp_pkg::REG_START_VERTEX, 63));
    tab.push_back(run_row(1, beat_of(0, 0, 0, 0, 1), '0));
    // An oversized count acts as the full store, rooted at the top vertex.
    tab.push_back(cfg_row(mstp_pkg::REG_VERTEX_COUNT, 63));
    tab.push_back(req_row(mstp_pkg::REQ_ADD, 31, 30, -1));
    tab.push_back(req_row(mstp_pkg::REQ_ADD, 0, 31, 7));
    tab.push_back(req_row(mstp_pkg::REQ_ADD, 5, 6, 32767));
    tab.push_back(req_row(mstp_pkg::REQ_ADD, 2, 3, 0));
    tab.push_back(req_row(mstp_pkg::REQ_ADD, 3, 4, 0));
    tab.push_back(req_row(mstp_pkg::REQ_ADD, 2, 4, 0));
    tab.push_back(req_row(mstp_pkg::REQ_ADD, 1, 2, -32768));
    tab.push_back(run_row(0, '0, '0));

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table.
    foreach (tab[k]) begin
      if (tab[k].kind == ROW_CFG) begin
        settle();
        write_reg(tab[k].cfg_idx, tab[k].cfg_val);
      end else begin
        send_beat(tab[k].rq, tab[k].n_typed, tab[k].first, tab[k].second);
        sender_gap();
      end
    end

    // Random phases, each under its own register setting; idle patterns change every two phases.
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      settle();
      if (phase < 2) begin
        req_idle_pct = 9;
        res_idle_pct = 48;
      end else if (phase < 4) begin
        req_idle_pct = 48;
        res_idle_pct = 9;
      end else begin
        req_idle_pct = 0;
        res_idle_pct = 0;
      end
      case (phase)
        0: begin
          cnt = $urandom_range(8, 2);
          st = $urandom_range(cnt - 1);
        end
        1: begin
          cnt = VMAX;
          st = 0;
        end
        2: begin
          cnt = $urandom_range(12, 3);
          st = $urandom_range(VMAX - 1);
        end
        3: begin
          cnt = 1;
          st = 0;
        end
        4: begin
          cnt = $urandom_range(16, 4);
          st = cnt - 1;
        end
        default: begin
          cnt = $urandom_range(10, 2);
          st = $urandom_range(VMAX - 1);
        end
      endcase
      write_reg(mstp_pkg::REG_VERTEX_COUNT, mstp_pkg::CFG_DATA_W'(cnt));
      write_reg(mstp_pkg::REG_START_VERTEX, mstp_pkg::CFG_DATA_W'(st));

      made = 0;
      while (made < PHASE_ITEMS) begin
        r = pick_request(clamped_count());
        // Early in the first phase a run meets a long result stall while the
        // sender keeps offering beats.
        if (phase == 0 && made == 10) r.rtype = mstp_pkg::REQ_RUN;
        send_beat(r, 0, '0, '0);
        if (phase == 0 && made == 10) stall_asked++;
        if (phase == 2 && made == 20) begin
          req_ch.valid <= 1'b0;
          wait_drained();
        end else begin
          sender_gap();
        end
        if (r.rtype != REQ_UNUSED) made++;
      end
    end

    req_ch.valid <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);
    $display("Checked %0d tree beats from %0d runs over %0d request beats,",
             n_checked, n_runs, n_beats);
    $display("with %0d register writes, both idle patterns, a long stall and a drain.",
             n_settings);
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin : watchdog
    #20_000_000;
    $error("run did not finish in time, %0d tree beats still due", tree_due.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: files.f
design/mstp_pkg.sv
design/mstp_if.sv
design/mstp_cmp.sv
design/mstp_adj_mem.sv
design/mstp_ctrl.sv
design/minimum_spanning_tree_prim_top.sv
design/mstp_chk.sv
sim/tb_top.sv
